### rtl/core/xrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xrs_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned BOUND_W = 32;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CHARS   = 8;

    // splitmix64 constants
    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

    typedef enum logic [1:0] {
        FUNC_RESEED  = 2'd0,
        FUNC_RAW     = 2'd1,
        FUNC_BOUNDED = 2'd2,
        FUNC_PRINT   = 2'd3
    } t_func;

    // printable alphabet: A-Z, a-z, 0-9, space, period
    function automatic logic [7:0] char_of(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26) begin
            c = 8'h41 + {2'b00, idx};
        end else if (idx < 6'd52) begin
            c = 8'h61 + {2'b00, idx} - 8'd26;
        end else if (idx < 6'd62) begin
            c = 8'h30 + {2'b00, idx} - 8'd52;
        end else if (idx == 6'd62) begin
            c = 8'h20;
        end else begin
            c = 8'h2e;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/xoroshiro_random_source.sv
`timescale 1ns / 1ps
`default_nettype none

// xoroshiro128** random source (rotations 24/16/37 and the rotl(s0*5,7)*9
// scrambler). Each input word carries a request: reseed from the seed
// register via two splitmix64 steps, a raw 64-bit draw, a draw reduced modulo
// a 32-bit bound, or up to eight printable characters. Every request returns
// exactly one output word; reseed, a zero bound and a zero count return 0;
// the last two leave the generator untouched. After reset the block first
// expands seed zero into the state and holds s_axis_tready low until done.
// The block takes one request at a time. A reseed runs two splitmix steps,
// each with two 64x64 low products built from three 32x32 partial products
// on one shared multiplier; a bounded draw waits on the bit-serial modulo
// unit that retires one dividend bit per cycle. The output register lets a
// new request enter while the previous result still waits on m_axis_tready.
module xoroshiro_random_source (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // seed register
    input  wire logic        i_seed_we,
    input  wire logic [63:0] i_seed_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // func[1:0], bound[33:2], byte_count[37:34]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // value[63:0]
);

    localparam int unsigned W = xrs_pkg::WORD_W;
    localparam int unsigned H = xrs_pkg::HALF_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SM_ADD,
        S_SM_MUL,
        S_DRAW_A,
        S_DRAW_B,
        S_POST,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    logic [W-1:0] r_seed;
    logic [W-1:0] r_s0;
    logic [W-1:0] r_s1;

    // request held for the whole operation
    xrs_pkg::t_func                r_func;
    logic [xrs_pkg::BOUND_W-1:0]   r_bound;
    logic [xrs_pkg::COUNT_W-1:0]   r_count;
    logic                          r_emit;   // low only for the expansion after reset

    // splitmix datapath
    logic [W-1:0] r_sm_seed;
    logic [W-1:0] r_z;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_prod;
    logic [1:0]   r_mstep;
    logic         r_mphase;   // 0: first multiply, 1: second
    logic         r_word_sel; // which state word is being built

    logic [W-1:0] r_word;
    logic [W-1:0] r_res;

    logic         r_out_valid;
    logic [W-1:0] r_out_data;

    // divider handshake
    logic                        w_div_start;
    logic                        w_div_done;
    logic [xrs_pkg::BOUND_W-1:0] w_div_rem;

    // combinational helpers
    logic [W-1:0] w_sm_x;
    logic [W-1:0] w_mconst;
    logic [H-1:0] w_mul_a;
    logic [H-1:0] w_mul_b;
    logic [W-1:0] w_mul_p;
    logic [W-1:0] w_fin;
    logic [W-1:0] w_s0x5;
    logic [W-1:0] w_b;
    logic [W-1:0] w_chars;
    logic [xrs_pkg::COUNT_W-1:0] w_cnt_sat;
    logic         w_accept;
    logic         w_out_free;

    xrs_pkg::t_func w_in_func;
    logic [xrs_pkg::BOUND_W-1:0] w_in_bound;
    logic [xrs_pkg::COUNT_W-1:0] w_in_count;

    assign w_in_func  = xrs_pkg::t_func'(s_axis_tdata[1:0]);
    assign w_in_bound = s_axis_tdata[33:2];
    assign w_in_count = s_axis_tdata[37:34];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        // splitmix increment; the first mix follows in S_SM_ADD
        w_sm_x = r_sm_seed + xrs_pkg::SM_GAMMA;

        // low 64 bits of z*M: zl*ml + ((zl*mh + zh*ml) << 32)
        w_mconst = r_mphase ? xrs_pkg::SM_MUL2 : xrs_pkg::SM_MUL1;
        w_mul_a  = (r_mstep == 2'd2) ? r_z[W-1:H] : r_z[H-1:0];
        w_mul_b  = (r_mstep == 2'd1) ? w_mconst[W-1:H] : w_mconst[H-1:0];
        w_mul_p  = {{H{1'b0}}, w_mul_a} * {{H{1'b0}}, w_mul_b};
        w_fin    = r_acc + {r_prod[H-1:0], {H{1'b0}}};

        // generator step
        w_s0x5 = r_s0 + {r_s0[W-3:0], 2'b00};
        w_b    = r_s1 ^ r_s0;

        // printable characters: clamp count to eight, zero the unused bytes
        w_cnt_sat = (r_count > 4'(xrs_pkg::CHARS)) ? 4'(xrs_pkg::CHARS) : r_count;
        for (int i = 0; i < xrs_pkg::CHARS; i++) begin
            w_chars[8*i +: 8] = (4'(i) < w_cnt_sat)
                              ? xrs_pkg::char_of(r_word[8*i +: 6]) : 8'h00;
        end
    end

    assign w_div_start = (r_state == S_POST) && (r_func == xrs_pkg::FUNC_BOUNDED);

    xrs_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_word),
        .i_divisor  (r_bound),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Seed register: written any time, used only when a reseed starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_seed_we) begin
            r_seed <= i_seed_data;
        end
    end

    // Sequencer, generator state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // expand seed zero before the first request
            r_state     <= S_SM_ADD;
            r_sm_seed   <= '0;
            r_word_sel  <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mstep     <= '0;
            r_mphase    <= 1'b0;
        end else begin
            // drop the taken word; in S_DONE the next word replaces it below
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func  <= w_in_func;
                        r_bound <= w_in_bound;
                        r_count <= w_in_count;
                        r_emit  <= 1'b1;
                        r_res   <= '0;
                        case (w_in_func)
                            xrs_pkg::FUNC_RESEED: begin
                                r_sm_seed  <= r_seed;
                                r_word_sel <= 1'b0;
                                r_state    <= S_SM_ADD;
                            end
                            xrs_pkg::FUNC_RAW: begin
                                r_state <= S_DRAW_A;
                            end
                            xrs_pkg::FUNC_BOUNDED: begin
                                r_state <= (w_in_bound == '0) ? S_DONE : S_DRAW_A;
                            end
                            default: begin
                                r_state <= (w_in_count == '0) ? S_DONE : S_DRAW_A;
                            end
                        endcase
                    end
                end

                S_SM_ADD: begin
                    r_sm_seed <= w_sm_x;
                    r_z       <= w_sm_x ^ (w_sm_x >> 30);
                    r_mstep   <= 2'd0;
                    r_mphase  <= 1'b0;
                    r_state   <= S_SM_MUL;
                end

                S_SM_MUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    r_prod  <= w_mul_p;
                    case (r_mstep)
                        2'd0: begin
                            r_acc <= '0;
                        end
                        2'd1: begin
                            r_acc <= r_prod;
                        end
                        2'd2: begin
                            r_acc <= w_fin;
                        end
                        default: begin
                            if (!r_mphase) begin
                                // feed the second multiply
                                r_z      <= w_fin ^ (w_fin >> 27);
                                r_mphase <= 1'b1;
                            end else begin
                                if (!r_word_sel) begin
                                    r_s0       <= w_fin ^ (w_fin >> 31);
                                    r_word_sel <= 1'b1;
                                    r_state    <= S_SM_ADD;
                                end else begin
                                    r_s1    <= w_fin ^ (w_fin >> 31);
                                    r_state <= r_emit ? S_DONE : S_IDLE;
                                end
                            end
                        end
                    endcase
                end

                S_DRAW_A: begin
                    // scrambler first half, advance state
                    r_word  <= {w_s0x5[W-8:0], w_s0x5[W-1:W-7]};
                    r_s0    <= {r_s0[W-25:0], r_s0[W-1:W-24]} ^ w_b ^ {w_b[W-17:0], 16'h0000};
                    r_s1    <= {w_b[W-38:0], w_b[W-1:W-37]};
                    r_state <= S_DRAW_B;
                end

                S_DRAW_B: begin
                    // times nine
                    r_word  <= r_word + {r_word[W-4:0], 3'b000};
                    r_state <= S_POST;
                end

                S_POST: begin
                    case (r_func)
                        xrs_pkg::FUNC_BOUNDED: begin
                            r_state <= S_DIV;
                        end
                        xrs_pkg::FUNC_PRINT: begin
                            r_res   <= w_chars;
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_res   <= r_word;
                            r_state <= S_DONE;
                        end
                    endcase
                end

                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= {{(W - xrs_pkg::BOUND_W){1'b0}}, w_div_rem};
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/xrs_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial restoring modulo: one dividend bit per cycle.
module xrs_mod_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [xrs_pkg::WORD_W-1:0]   i_dividend,
    input  wire logic [xrs_pkg::BOUND_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic [xrs_pkg::BOUND_W-1:0]       o_rem
);

    localparam int unsigned CNT_W = $clog2(xrs_pkg::WORD_W);

    logic [xrs_pkg::WORD_W-1:0]  r_dvd;
    logic [xrs_pkg::BOUND_W-1:0] r_div;
    logic [xrs_pkg::BOUND_W-1:0] r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [xrs_pkg::BOUND_W:0]   w_trial;
    logic [xrs_pkg::BOUND_W+1:0] w_diff;
    logic [xrs_pkg::BOUND_W-1:0] w_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[xrs_pkg::WORD_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_div};
        w_rem   = w_diff[xrs_pkg::BOUND_W+1] ? w_trial[xrs_pkg::BOUND_W-1:0]
                                              : w_diff[xrs_pkg::BOUND_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(xrs_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[xrs_pkg::WORD_W-2:0], 1'b0};
            r_rem <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
